// ----- rtl/core/cdt_pkg.sv -----
// types, constants and encodings shared by the countdown timer / led pwm core
// no dependencies
`default_nettype none

package cdt_pkg;

	// pwm and timing constants
	localparam logic [15:0] FULL_PERIOD      = 16'd40000;
	localparam logic [15:0] DUTY_MARGIN      = 16'd300;
	localparam logic [15:0] BREATHE_TOP      = FULL_PERIOD - DUTY_MARGIN;
	localparam logic [15:0] ENTRY_DUTY       = 16'd100;
	localparam logic [15:0] DUTY_RESET       = 16'd20000;
	localparam logic [5:0]  ADC_GAIN         = 6'd38;
	localparam logic [12:0] FINISH_HOLD      = 13'd5;
	localparam logic [3:0]  CHANGE_LIMIT     = 4'd10;
	localparam logic [6:0]  MAX_TYPED        = 7'd99;
	localparam logic [6:0]  SECS_PER_MIN     = 7'd60;
	localparam logic [15:0] HELD_MAX         = 16'hFFFF;
	localparam logic [8:0]  DUTY_STEP_RESET  = 9'd200;
	localparam logic [7:0]  HOLD_LIMIT_RESET = 8'd3;

	// button gestures
	localparam logic [2:0] BTN_ENTRY = 3'b001;
	localparam logic [2:0] BTN_CLEAR = 3'b010;
	localparam logic [2:0] BTN_PAUSE = 3'b100;

	typedef enum logic [2:0] {
		MODE_WAIT   = 3'd0,
		MODE_ENTRY  = 3'd1,
		MODE_COUNT  = 3'd2,
		MODE_PAUSE  = 3'd3,
		MODE_FINISH = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		REQ_TICK   = 2'd0,
		REQ_BUTTON = 2'd1,
		REQ_WINDOW = 2'd2,
		REQ_PWM    = 2'd3
	} req_kind_t;

	typedef enum logic {
		REG_DUTY_STEP  = 1'b0,
		REG_HOLD_LIMIT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [2:0] buttons;
		logic [6:0] entry_minutes;
		logic [6:0] entry_seconds;
		logic [9:0] adc_sample;
	} req_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [12:0] remaining_seconds;
		logic [15:0] duty_cycles;
		logic        led_on;
		logic [15:0] period_cycles;
	} rsp_t;

	typedef struct packed {
		logic [8:0] duty_step;
		logic [7:0] hold_limit;
	} cfg_t;

	typedef struct packed {
		mode_t       mode;
		logic [12:0] remaining;
		logic [15:0] duty;
		logic        duty_rising;
		logic        breathing_on;
		logic        high_half_next;
		logic        blink_lit;
		logic [2:0]  buttons_now;
		logic [2:0]  buttons_seen;
		logic [3:0]  changes;
		logic        holding;
		logic [15:0] held_seconds;
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/core/cdt_apb_regs.sv -----
// apb register file: breathing duty step and hold limit
// depends on cdt_pkg
`default_nettype none

module cdt_apb_regs (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output cdt_pkg::cfg_t     cfg
);

	logic [8:0] duty_step_q;
	logic [7:0] hold_limit_q;
	logic       wr_en;

	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_step_q  <= cdt_pkg::DUTY_STEP_RESET;
			hold_limit_q <= cdt_pkg::HOLD_LIMIT_RESET;
		end else if (wr_en) begin
			case (cdt_pkg::reg_idx_t'(paddr[2]))
				cdt_pkg::REG_DUTY_STEP:  duty_step_q  <= pwdata[8:0];
				cdt_pkg::REG_HOLD_LIMIT: hold_limit_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cdt_pkg::reg_idx_t'(paddr[2]))
			cdt_pkg::REG_DUTY_STEP:  prdata = {23'd0, duty_step_q};
			cdt_pkg::REG_HOLD_LIMIT: prdata = {24'd0, hold_limit_q};
			default:                 prdata = '0;
		endcase
	end

	assign cfg.duty_step  = duty_step_q;
	assign cfg.hold_limit = hold_limit_q;

endmodule

`default_nettype wire

// ----- rtl/core/cdt_step.sv -----
// single-pass update: next timer/led state and the result for one item
// depends on cdt_pkg
`default_nettype none

module cdt_step (
	input  wire cdt_pkg::state_t  cur,
	input  wire cdt_pkg::req_t    req,
	input  wire cdt_pkg::cfg_t    cfg,
	output cdt_pkg::state_t       nxt,
	output cdt_pkg::rsp_t         rsp
);

	logic [16:0] lit_sum;
	logic [15:0] lit_duty;
	logic        br_rising;
	logic [16:0] br_up;
	logic [15:0] br_up_clamped;
	logic [15:0] br_down;
	logic [15:0] br_duty;
	logic [6:0]  mins_sat;
	logic [6:0]  secs_sat;
	logic [12:0] typed_total;
	logic [12:0] rem_inc;
	logic [15:0] period;
	logic        hold_reset;

	// converter-driven brightness, clamped to the period
	assign lit_sum  = {1'b0, cdt_pkg::ENTRY_DUTY}
		+ ({7'd0, req.adc_sample} * {11'd0, cdt_pkg::ADC_GAIN});
	assign lit_duty = (lit_sum > {1'b0, cdt_pkg::FULL_PERIOD}) ? cdt_pkg::FULL_PERIOD
		: lit_sum[15:0];

	// triangular breathing step
	always_comb begin
		if (cur.duty >= cdt_pkg::BREATHE_TOP)
			br_rising = 1'b0;
		else if (cur.duty <= cdt_pkg::DUTY_MARGIN)
			br_rising = 1'b1;
		else
			br_rising = cur.duty_rising;
	end

	assign br_up         = {1'b0, cur.duty} + {8'd0, cfg.duty_step};
	assign br_up_clamped = (br_up > {1'b0, cdt_pkg::FULL_PERIOD}) ? cdt_pkg::FULL_PERIOD
		: br_up[15:0];
	assign br_down       = (cur.duty > {7'd0, cfg.duty_step})
		? cur.duty - {7'd0, cfg.duty_step} : '0;
	assign br_duty       = br_rising ? br_up_clamped : br_down;

	// typed time, each field saturated
	assign mins_sat    = (req.entry_minutes > cdt_pkg::MAX_TYPED) ? cdt_pkg::MAX_TYPED
		: req.entry_minutes;
	assign secs_sat    = (req.entry_seconds > cdt_pkg::MAX_TYPED) ? cdt_pkg::MAX_TYPED
		: req.entry_seconds;
	assign typed_total = ({6'd0, mins_sat} * {6'd0, cdt_pkg::SECS_PER_MIN})
		+ {6'd0, secs_sat};

	assign rem_inc    = cur.remaining + 13'd1;
	assign hold_reset = cur.held_seconds >= {8'd0, cfg.hold_limit};
	assign period     = cur.high_half_next ? cur.duty : cdt_pkg::FULL_PERIOD - cur.duty;

	// next state
	always_comb begin
		nxt = cur;
		case (req.req_type)
			cdt_pkg::REQ_TICK: begin
				case (cur.mode)
					cdt_pkg::MODE_WAIT: nxt.breathing_on = 1'b1;
					cdt_pkg::MODE_ENTRY: begin
						nxt.breathing_on = 1'b0;
						nxt.duty         = cdt_pkg::ENTRY_DUTY;
					end
					cdt_pkg::MODE_COUNT: begin
						nxt.blink_lit = !cur.blink_lit;
						nxt.duty      = !cur.blink_lit ? lit_duty : cdt_pkg::ENTRY_DUTY;
						if (cur.remaining <= 13'd1)
							nxt.mode = cdt_pkg::MODE_FINISH;
						else
							nxt.remaining = cur.remaining - 13'd1;
						if (cur.holding && cur.held_seconds < cdt_pkg::HELD_MAX)
							nxt.held_seconds = cur.held_seconds + 16'd1;
					end
					cdt_pkg::MODE_PAUSE: begin
						nxt.duty = cur.blink_lit ? lit_duty : cdt_pkg::ENTRY_DUTY;
					end
					cdt_pkg::MODE_FINISH: begin
						nxt.duty = lit_duty;
						if (rem_inc == cdt_pkg::FINISH_HOLD) begin
							nxt.mode      = cdt_pkg::MODE_WAIT;
							nxt.remaining = '0;
						end else begin
							nxt.remaining = rem_inc;
						end
					end
					default: ;
				endcase
			end
			cdt_pkg::REQ_BUTTON: begin
				// changes beyond the limit are dropped until the window ends
				if (cur.changes < cdt_pkg::CHANGE_LIMIT) begin
					nxt.changes      = cur.changes + 4'd1;
					nxt.buttons_seen = cur.buttons_seen | cur.buttons_now;
					nxt.buttons_now  = req.buttons;
				end
			end
			cdt_pkg::REQ_WINDOW: begin
				if (cur.buttons_now == 3'd0) begin
					case (cur.mode)
						cdt_pkg::MODE_WAIT: begin
							if (cur.buttons_seen == cdt_pkg::BTN_ENTRY)
								nxt.mode = cdt_pkg::MODE_ENTRY;
						end
						cdt_pkg::MODE_ENTRY: begin
							nxt.remaining = typed_total;
							if (cur.buttons_seen == cdt_pkg::BTN_PAUSE)
								nxt.mode = cdt_pkg::MODE_COUNT;
							else if (cur.buttons_seen == cdt_pkg::BTN_CLEAR)
								nxt.remaining = '0;
						end
						cdt_pkg::MODE_COUNT: begin
							if (cur.buttons_seen == cdt_pkg::BTN_PAUSE) begin
								if (hold_reset) begin
									nxt.held_seconds = '0;
									nxt.remaining    = '0;
									nxt.mode         = cdt_pkg::MODE_ENTRY;
								end else begin
									nxt.mode = cdt_pkg::MODE_PAUSE;
								end
							end
						end
						cdt_pkg::MODE_PAUSE: begin
							if (cur.buttons_seen == cdt_pkg::BTN_PAUSE)
								nxt.mode = cdt_pkg::MODE_COUNT;
						end
						default: ;
					endcase
				end
				// holding follows the mode left by this window
				nxt.holding      = (cur.buttons_now == cdt_pkg::BTN_PAUSE)
					&& (nxt.mode == cdt_pkg::MODE_COUNT);
				nxt.buttons_seen = '0;
				nxt.changes      = '0;
			end
			cdt_pkg::REQ_PWM: begin
				nxt.high_half_next = !cur.high_half_next;
				if (cur.breathing_on) begin
					nxt.duty_rising = br_rising;
					nxt.duty        = br_duty;
				end
			end
			default: ;
		endcase
	end

	// result fields
	always_comb begin
		rsp.mode              = nxt.mode;
		rsp.remaining_seconds = nxt.remaining;
		rsp.duty_cycles       = nxt.duty;
		rsp.led_on            = !nxt.high_half_next;
		rsp.period_cycles     = (req.req_type == cdt_pkg::REQ_PWM) ? period : '0;
	end

endmodule

`default_nettype wire

// ----- rtl/core/countdown_timer_with_led_pwm_core.sv -----
// channel   | direction | handshake            | payload
// req       | in        | req_valid/req_stall  | cdt_pkg::req_t
// rsp       | out       | rsp_valid/rsp_stall  | cdt_pkg::rsp_t
// apb       | in/out    | psel/penable/pready  | duty_step, hold_limit
//
// one item per cycle while results are not stalled; an accepted item passes
// through the input register, the single-pass update and the result register,
// where its result waits until it is taken
// reset puts the timer in wait mode, duty at mid period, breathing on
// a stalled result holds its register; the input register keeps taking items
// while the result register is free or being emptied
// depends on cdt_pkg, cdt_apb_regs, cdt_step
`default_nettype none

module countdown_timer_with_led_pwm_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  wire logic         req_valid,
	output logic              req_stall,
	input  wire cdt_pkg::req_t req,
	output logic              rsp_valid,
	input  wire logic         rsp_stall,
	output cdt_pkg::rsp_t     rsp
);

	cdt_pkg::cfg_t   cfg;
	cdt_pkg::state_t state_q;
	cdt_pkg::state_t state_nxt;
	cdt_pkg::req_t   req_s1;
	cdt_pkg::rsp_t   rsp_nxt;
	cdt_pkg::rsp_t   rsp_s2;
	logic            valid_s1;
	logic            valid_s2;
	logic            advance;
	logic            accept;

	assign pready = 1'b1;

	cdt_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	cdt_step u_step (
		.cur (state_q),
		.req (req_s1),
		.cfg (cfg),
		.nxt (state_nxt),
		.rsp (rsp_nxt)
	);

	assign advance   = valid_s1 && (!valid_s2 || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign accept    = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				valid_s2 <= 1'b1;
			else if (!rsp_stall)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			req_s1 <= req;
		if (advance)
			rsp_s2 <= rsp_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode           <= cdt_pkg::MODE_WAIT;
			state_q.remaining      <= '0;
			state_q.duty           <= cdt_pkg::DUTY_RESET;
			state_q.duty_rising    <= 1'b1;
			state_q.breathing_on   <= 1'b1;
			state_q.high_half_next <= 1'b1;
			state_q.blink_lit      <= 1'b0;
			state_q.buttons_now    <= '0;
			state_q.buttons_seen   <= '0;
			state_q.changes        <= '0;
			state_q.holding        <= 1'b0;
			state_q.held_seconds   <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	// duty never leaves the pwm period
	a_duty_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.duty <= cdt_pkg::FULL_PERIOD)
		else $error("duty beyond full period");

	// window change count stays within its limit
	a_change_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.changes <= cdt_pkg::CHANGE_LIMIT)
		else $error("change count beyond limit");

	// only pwm items report a period
	a_period_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && req_s1.req_type != cdt_pkg::REQ_PWM) |=> (rsp_s2.period_cycles == '0))
		else $error("non-pwm item reported a period");

	// a waiting result matches the state it left behind
	a_rsp_state: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (rsp_s2.mode == state_q.mode
			&& rsp_s2.led_on == !state_q.high_half_next
			&& rsp_s2.duty_cycles == state_q.duty))
		else $error("result out of step with state");

endmodule

`default_nettype wire

// ----- tb/countdown_timer_with_led_pwm_core_tb.sv -----
// self-checking testbench for the countdown timer / led pwm core: gesture, tick and pwm
// events against a cycle-free model of the timer kept in this file
// depends on cdt_pkg and countdown_timer_with_led_pwm_core
`timescale 1ns / 100ps

module countdown_timer_with_led_pwm_core_tb;

	localparam int unsigned STUCK_LIMIT = 4000;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          psel = 1'b0;
	logic          penable = 1'b0;
	logic          pwrite = 1'b0;
	logic [2:0]    paddr = '0;
	logic [31:0]   pwdata = '0;
	logic [31:0]   prdata;
	logic          pready;
	logic          req_valid = 1'b0;
	logic          req_stall;
	cdt_pkg::req_t req = '0;
	logic          rsp_valid;
	logic          rsp_stall = 1'b0;
	cdt_pkg::rsp_t rsp;

	// timer model state and settings
	cdt_pkg::mode_t tm_mode;
	logic [12:0]    tm_remaining;
	logic [15:0]    tm_duty;
	logic           tm_rising;
	logic           tm_breathing;
	logic           tm_high_next;
	logic           tm_blink;
	logic [2:0]     tm_now;
	logic [2:0]     tm_seen;
	logic [3:0]     tm_changes;
	logic           tm_holding;
	logic [15:0]    tm_held;
	logic [8:0]     tm_step;
	logic [7:0]     tm_hold_limit;

	cdt_pkg::rsp_t status_q[$];
	int unsigned   src_idle_pct = 0;
	int unsigned   snk_idle_pct = 0;
	int unsigned   items_sent = 0;
	int unsigned   fails = 0;
	int unsigned   stuck_cycles = 0;

	countdown_timer_with_led_pwm_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void timer_reset();
		tm_mode       = cdt_pkg::MODE_WAIT;
		tm_remaining  = '0;
		tm_duty       = cdt_pkg::DUTY_RESET;
		tm_rising     = 1'b1;
		tm_breathing  = 1'b1;
		tm_high_next  = 1'b1;
		tm_blink      = 1'b0;
		tm_now        = '0;
		tm_seen       = '0;
		tm_changes    = '0;
		tm_holding    = 1'b0;
		tm_held       = '0;
		tm_step       = cdt_pkg::DUTY_STEP_RESET;
		tm_hold_limit = cdt_pkg::HOLD_LIMIT_RESET;
	endfunction

	function automatic logic [15:0] limit_duty(int v);
		return (v > int'(cdt_pkg::FULL_PERIOD)) ? cdt_pkg::FULL_PERIOD : 16'(v);
	endfunction

	// advances the model by one event and returns the status it reports
	function automatic cdt_pkg::rsp_t timer_update(cdt_pkg::req_t r);
		cdt_pkg::rsp_t o;
		int            lit;
		int            mins;
		int            secs;
		logic [15:0]   period;
		period = '0;
		lit = int'(cdt_pkg::ENTRY_DUTY) + int'(r.adc_sample) * int'(cdt_pkg::ADC_GAIN);
		case (cdt_pkg::req_kind_t'(r.req_type))
		cdt_pkg::REQ_TICK: begin
			case (tm_mode)
			cdt_pkg::MODE_WAIT: tm_breathing = 1'b1;
			cdt_pkg::MODE_ENTRY: begin
				tm_breathing = 1'b0;
				tm_duty = cdt_pkg::ENTRY_DUTY;
			end
			cdt_pkg::MODE_COUNT: begin
				tm_blink = !tm_blink;
				tm_duty = limit_duty(tm_blink ? lit : int'(cdt_pkg::ENTRY_DUTY));
				if (tm_remaining <= 13'd1)
					tm_mode = cdt_pkg::MODE_FINISH;
				else
					tm_remaining = tm_remaining - 13'd1;
				if (tm_holding && tm_held != cdt_pkg::HELD_MAX)
					tm_held = tm_held + 16'd1;
			end
			cdt_pkg::MODE_PAUSE:
				tm_duty = limit_duty(tm_blink ? lit : int'(cdt_pkg::ENTRY_DUTY));
			cdt_pkg::MODE_FINISH: begin
				tm_duty = limit_duty(lit);
				tm_remaining = tm_remaining + 13'd1;
				if (tm_remaining == cdt_pkg::FINISH_HOLD) begin
					tm_mode = cdt_pkg::MODE_WAIT;
					tm_remaining = '0;
				end
			end
			default: ;
			endcase
		end
		cdt_pkg::REQ_BUTTON: begin
			if (tm_changes < cdt_pkg::CHANGE_LIMIT) begin
				tm_changes = tm_changes + 4'd1;
				tm_seen = tm_seen | tm_now;
				tm_now = r.buttons;
			end
		end
		cdt_pkg::REQ_WINDOW: begin
			// a gesture only counts once every button is released
			if (tm_now == 3'b000) begin
				case (tm_mode)
				cdt_pkg::MODE_WAIT: begin
					if (tm_seen == cdt_pkg::BTN_ENTRY)
						tm_mode = cdt_pkg::MODE_ENTRY;
				end
				cdt_pkg::MODE_ENTRY: begin
					mins = (r.entry_minutes > cdt_pkg::MAX_TYPED) ? int'(cdt_pkg::MAX_TYPED)
						: int'(r.entry_minutes);
					secs = (r.entry_seconds > cdt_pkg::MAX_TYPED) ? int'(cdt_pkg::MAX_TYPED)
						: int'(r.entry_seconds);
					tm_remaining = 13'(mins * int'(cdt_pkg::SECS_PER_MIN) + secs);
					if (tm_seen == cdt_pkg::BTN_PAUSE)
						tm_mode = cdt_pkg::MODE_COUNT;
					else if (tm_seen == cdt_pkg::BTN_CLEAR)
						tm_remaining = '0;
				end
				cdt_pkg::MODE_COUNT: begin
					if (tm_seen == cdt_pkg::BTN_PAUSE) begin
						if (tm_held >= 16'(tm_hold_limit)) begin
							tm_held = '0;
							tm_remaining = '0;
							tm_mode = cdt_pkg::MODE_ENTRY;
						end else begin
							tm_mode = cdt_pkg::MODE_PAUSE;
						end
					end
				end
				cdt_pkg::MODE_PAUSE: begin
					if (tm_seen == cdt_pkg::BTN_PAUSE)
						tm_mode = cdt_pkg::MODE_COUNT;
				end
				default: ;
				endcase
			end
			tm_holding = (tm_now == cdt_pkg::BTN_PAUSE) && (tm_mode == cdt_pkg::MODE_COUNT);
			tm_seen = '0;
			tm_changes = '0;
		end
		default: begin
			if (tm_high_next)
				period = tm_duty;
			else
				period = cdt_pkg::FULL_PERIOD - tm_duty;
			tm_high_next = !tm_high_next;
			if (tm_breathing) begin
				if (tm_duty >= cdt_pkg::BREATHE_TOP)
					tm_rising = 1'b0;
				else if (tm_duty <= cdt_pkg::DUTY_MARGIN)
					tm_rising = 1'b1;
				if (tm_rising)
					tm_duty = limit_duty(int'(tm_duty) + int'(tm_step));
				else
					tm_duty = (tm_duty > 16'(tm_step)) ? tm_duty - 16'(tm_step) : 16'd0;
			end
		end
		endcase
		o.mode              = tm_mode;
		o.remaining_seconds = tm_remaining;
		o.duty_cycles       = tm_duty;
		o.led_on            = !tm_high_next;
		o.period_cycles     = period;
		return o;
	endfunction

	// result side: check, random stall, watchdog
	always @(posedge clk) begin
		cdt_pkg::rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (status_q.size() == 0) begin
					$error("result with nothing expected");
					fails++;
				end else begin
					want = status_q.pop_front();
					if (rsp.mode !== want.mode) begin
						$error("mode: expected %0d, got %0d", want.mode, rsp.mode);
						fails++;
					end
					if (rsp.remaining_seconds !== want.remaining_seconds) begin
						$error("remaining_seconds: expected %0d, got %0d",
							want.remaining_seconds, rsp.remaining_seconds);
						fails++;
					end
					if (rsp.duty_cycles !== want.duty_cycles) begin
						$error("duty_cycles: expected %0d, got %0d",
							want.duty_cycles, rsp.duty_cycles);
						fails++;
					end
					if (rsp.led_on !== want.led_on) begin
						$error("led_on: expected %0d, got %0d", want.led_on, rsp.led_on);
						fails++;
					end
					if (rsp.period_cycles !== want.period_cycles) begin
						$error("period_cycles: expected %0d, got %0d",
							want.period_cycles, rsp.period_cycles);
						fails++;
					end
				end
			end
			if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("countdown_timer_with_led_pwm_core regression: fail");
				$finish;
			end
			rsp_stall <= ($urandom_range(99) < snk_idle_pct);
		end
	end

	task automatic send_item(cdt_pkg::req_t r);
		while ($urandom_range(99) < src_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		status_q.push_back(timer_update(r));
		items_sent++;
	endtask

	// event of the given kind with random content in the fields it ignores
	function automatic cdt_pkg::req_t any_req(cdt_pkg::req_kind_t kind);
		logic [31:0]   raw;
		cdt_pkg::req_t r;
		raw = $urandom;
		r = cdt_pkg::req_t'(raw[$bits(cdt_pkg::req_t)-1:0]);
		r.req_type = kind;
		return r;
	endfunction

	task automatic send_tick(logic [9:0] adc);
		cdt_pkg::req_t r;
		r = any_req(cdt_pkg::REQ_TICK);
		r.adc_sample = adc;
		send_item(r);
	endtask

	task automatic send_button(logic [2:0] b);
		cdt_pkg::req_t r;
		r = any_req(cdt_pkg::REQ_BUTTON);
		r.buttons = b;
		send_item(r);
	endtask

	task automatic send_window(logic [6:0] mins, logic [6:0] secs);
		cdt_pkg::req_t r;
		r = any_req(cdt_pkg::REQ_WINDOW);
		r.entry_minutes = mins;
		r.entry_seconds = secs;
		send_item(r);
	endtask

	task automatic send_pwm();
		send_item(any_req(cdt_pkg::REQ_PWM));
	endtask

	task automatic send_gesture(logic [2:0] b, logic [6:0] mins, logic [6:0] secs);
		send_button(b);
		send_button(3'b000);
		send_window(mins, secs);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (status_q.size() != 0);
	endtask

	task automatic write_reg(cdt_pkg::reg_idx_t idx, logic [31:0] value);
		logic [31:0] got;
		logic [31:0] want;
		logic [31:0] mask;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (idx == cdt_pkg::REG_DUTY_STEP)
			tm_step = value[8:0];
		else
			tm_hold_limit = value[7:0];
		// read it back
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		mask = (idx == cdt_pkg::REG_DUTY_STEP) ? 32'h1FF : 32'hFF;
		want = (idx == cdt_pkg::REG_DUTY_STEP) ? 32'(tm_step) : 32'(tm_hold_limit);
		if ((got & mask) !== want) begin
			$error("prdata: expected %0d, got %0d", want, got & mask);
			fails++;
		end
	endtask

	task automatic set_timing(logic [8:0] step, logic [7:0] hold);
		drain();
		write_reg(cdt_pkg::REG_DUTY_STEP, 32'(step));
		write_reg(cdt_pkg::REG_HOLD_LIMIT, 32'(hold));
	endtask

	// brings the timer to entry mode with no buttons pending
	task automatic reach_entry();
		send_window(7'($urandom), 7'($urandom));
		send_button(3'b000);
		send_window(7'($urandom), 7'($urandom));
		while (tm_mode != cdt_pkg::MODE_WAIT && tm_mode != cdt_pkg::MODE_ENTRY) begin
			if (tm_mode == cdt_pkg::MODE_PAUSE) begin
				send_gesture(cdt_pkg::BTN_PAUSE, 7'($urandom), 7'($urandom));
			end else if (tm_mode == cdt_pkg::MODE_COUNT) begin
				// short hold of start/pause; each one brings the hold limit closer
				send_button(cdt_pkg::BTN_PAUSE);
				send_window(7'($urandom), 7'($urandom));
				send_tick(10'($urandom));
				send_button(3'b000);
				send_window(7'($urandom), 7'($urandom));
			end else begin
				send_tick(10'($urandom));
			end
		end
		if (tm_mode == cdt_pkg::MODE_WAIT)
			send_gesture(cdt_pkg::BTN_ENTRY, 7'($urandom), 7'($urandom));
	endtask

	task automatic test_directed();
		send_pwm();
		send_pwm();
		send_tick(10'd1023);
		send_gesture(cdt_pkg::BTN_ENTRY, 7'd0, 7'd0);
		send_tick(10'd0);
		send_pwm();
		// typed values above 99 saturate, then clear drops them
		send_gesture(cdt_pkg::BTN_CLEAR, 7'd127, 7'd127);
		send_gesture(cdt_pkg::BTN_PAUSE, 7'd0, 7'd2);
		send_tick(10'd1023);
		send_tick(10'd0);
		send_tick(10'd512);
		send_window(7'd127, 7'd0);
		send_button(3'b111);
		send_window(7'd0, 7'd127);
		send_tick(10'd1);
		send_pwm();
	endtask

	task automatic test_random_events(int unsigned n);
		int unsigned stop_at;
		int unsigned pick;
		int unsigned len;
		logic [2:0]  b;
		logic [6:0]  mins;
		logic [6:0]  secs;
		logic [31:0] raw;
		stop_at = items_sent + n;
		while (items_sent < stop_at) begin
			pick = $urandom_range(99);
			if ($urandom_range(4) == 0) begin
				mins = 7'($urandom);
				secs = 7'($urandom);
			end else begin
				mins = '0;
				secs = 7'($urandom_range(20));
			end
			if (pick < 22) begin
				case ($urandom_range(3))
				0: b = cdt_pkg::BTN_ENTRY;
				1: b = cdt_pkg::BTN_CLEAR;
				2: b = cdt_pkg::BTN_PAUSE;
				default: b = 3'($urandom);
				endcase
				send_gesture(b, mins, secs);
			end else if (pick < 30) begin
				// hold start/pause across some ticks, then release
				send_button(cdt_pkg::BTN_PAUSE);
				send_window(mins, secs);
				len = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(6);
				repeat (len)
					send_tick(10'($urandom));
				send_button(3'b000);
				send_window(mins, secs);
			end else if (pick < 52) begin
				repeat ($urandom_range(1, 8))
					send_tick(10'($urandom));
			end else if (pick < 70) begin
				repeat ($urandom_range(1, 12))
					send_pwm();
			end else if (pick < 82) begin
				raw = $urandom;
				send_item(cdt_pkg::req_t'(raw[$bits(cdt_pkg::req_t)-1:0]));
			end else if (pick < 88) begin
				// nine to fourteen changes, often more than one window takes
				repeat ($urandom_range(9, 14))
					send_button(3'($urandom));
				send_window(mins, secs);
			end else if (pick < 97) begin
				if ($urandom_range(1))
					send_button(3'($urandom));
				else
					send_window(mins, secs);
			end else begin
				drain();
			end
		end
	endtask

	// short countdowns with start/pause held for a few ticks, then released,
	// giving a hold reset or a pause depending on the hold count
	task automatic test_hold_reset();
		int unsigned len;
		repeat (3) begin
			reach_entry();
			send_gesture(cdt_pkg::BTN_PAUSE, 7'd0, 7'd40);
			send_button(cdt_pkg::BTN_PAUSE);
			send_window(7'($urandom), 7'($urandom));
			len = $urandom_range(1, 8);
			repeat (len)
				send_tick(10'($urandom));
			send_button(3'b000);
			send_window(7'($urandom), 7'($urandom));
		end
	endtask

	initial begin
		timer_reset();
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 15;
		snk_idle_pct = 62;
		test_directed();
		test_random_events(500);

		set_timing(9'd300, 8'd1);
		src_idle_pct = 62;
		snk_idle_pct = 15;
		test_random_events(500);

		set_timing(9'd1, 8'd4);
		src_idle_pct = 0;
		snk_idle_pct = 0;
		test_hold_reset();

		set_timing(9'($urandom_range(1, 300)), 8'($urandom_range(1, 255)));
		test_random_events(500);

		drain();
		repeat (4)
			@(posedge clk);
		if (fails == 0 && status_q.size() == 0)
			$display("countdown_timer_with_led_pwm_core regression: pass");
		else
			$display("countdown_timer_with_led_pwm_core regression: fail");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/cdt_pkg.sv
rtl/core/cdt_apb_regs.sv
rtl/core/cdt_step.sv
rtl/core/countdown_timer_with_led_pwm_core.sv
tb/countdown_timer_with_led_pwm_core_tb.sv
